>>> src/postfix_expression_evaluator_assert.svh
// assertion macros for the postfix evaluator
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// property must hold at every clock edge out of reset
`define PEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define PEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pee_pkg.sv
package pee_pkg;

  localparam logic [7:0] SymPow   = 8'h5e;
  localparam logic [7:0] SymDiv   = 8'h2f;
  localparam logic [7:0] SymMul   = 8'h2a;
  localparam logic [7:0] SymMod   = 8'h25;
  localparam logic [7:0] SymAdd   = 8'h2b;
  localparam logic [7:0] SymSub   = 8'h2d;
  localparam logic [7:0] SymZero  = 8'h30;
  localparam logic [7:0] SymNine  = 8'h39;
  localparam logic [7:0] SymSpace = 8'h20;

  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrUnderflow = 3'd1;
  localparam logic [2:0] ErrOverflow  = 3'd2;
  localparam logic [2:0] ErrDivZero   = 3'd3;
  localparam logic [2:0] ErrBadSym    = 3'd4;
  localparam logic [2:0] ErrLeftover  = 3'd5;

  typedef enum logic [2:0] {
    OpAdd, OpSub, OpMul, OpDiv, OpMod, OpPow
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load_sym;   // capture incoming request
    logic rd_top;     // launch stack read of top
    logic rd_next;    // launch stack read of second
    logic cap_rhs;    // latch read data as rhs
    logic cap_lhs;    // latch read data as lhs
    logic push_digit;
    logic start_alu;
    logic push_res;
    logic pop2;
    logic set_err;
    logic [2:0] err;
    logic cap_out;
    logic finish;     // clear stack depth and error
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_space;
    logic is_digit;
    logic is_op;
    logic is_div;
    logic rhs_zero;
    logic full;
    logic lt_two;
    logic err_set;
    logic last;
    logic alu_done;
  } sts_t;

endpackage

>>> src/pee_alu.sv
module pee_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pee_pkg::op_e     op_i,
  input  logic [31:0]      lhs_i,
  input  logic [31:0]      rhs_i,
  output logic             done_o,
  output logic [31:0]      res_o
);
  import pee_pkg::*;

  // division: restoring, one quotient bit per cycle on magnitudes
  // power: one exponent bit per cycle, two multiplies share the cycle
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  op_e         op_q;
  logic [31:0] acc_q, acc_d;   // quotient or power result
  logic [31:0] rem_q, rem_d;   // remainder or squared base
  logic [31:0] div_q, div_d;   // divisor magnitude or exponent
  logic        neg_q_q, neg_r_q;
  logic [31:0] res_q, res_d;
  logic        done_q, done_d;

  logic [31:0] lmag, rmag;
  logic [32:0] trial;
  logic [31:0] shl_rem;

  assign lmag = lhs_i[31] ? (32'd0 - lhs_i) : lhs_i;
  assign rmag = rhs_i[31] ? (32'd0 - rhs_i) : rhs_i;
  assign shl_rem = {rem_q[30:0], acc_q[31]};
  assign trial = {1'b0, shl_rem} - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    div_d  = div_q;
    res_d  = res_q;
    done_d = 1'b0;
    if (start_i) begin
      unique case (op_i)
        OpAdd: begin res_d = lhs_i + rhs_i; done_d = 1'b1; end
        OpSub: begin res_d = lhs_i - rhs_i; done_d = 1'b1; end
        OpMul: begin res_d = lhs_i * rhs_i; done_d = 1'b1; end
        OpPow: begin
          if (rhs_i[31]) begin
            done_d = 1'b1;
            if (lhs_i == 32'd1) res_d = 32'd1;
            else if (lhs_i == 32'hffff_ffff) res_d = rhs_i[0] ? 32'hffff_ffff : 32'd1;
            else res_d = 32'd0;
          end else begin
            busy_d = 1'b1;
            cnt_d  = 6'd31;
            acc_d  = 32'd1;
            rem_d  = lhs_i;
            div_d  = rhs_i;
          end
        end
        OpDiv, OpMod: begin
          busy_d = 1'b1;
          cnt_d  = 6'd32;
          acc_d  = lmag;
          rem_d  = 32'd0;
          div_d  = rmag;
        end
        default: ;
      endcase
    end else if (busy_q) begin
      if (op_q == OpPow) begin
        if (div_q[0]) acc_d = acc_q * rem_q;
        rem_d = rem_q * rem_q;
        div_d = {1'b0, div_q[31:1]};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = div_q[0] ? acc_q * rem_q : acc_q;
        end
      end else begin
        if (!trial[32]) begin
          rem_d = trial[31:0];
          acc_d = {acc_q[30:0], 1'b1};
        end else begin
          rem_d = shl_rem;
          acc_d = {acc_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_d = 1'b0;
          done_d = 1'b1;
          if (op_q == OpDiv) res_d = neg_q_q ? (32'd0 - acc_d) : acc_d;
          else res_d = neg_r_q ? (32'd0 - rem_d) : rem_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    div_q <= div_d;
    res_q <= res_d;
    if (start_i) begin
      op_q    <= op_i;
      neg_q_q <= lhs_i[31] ^ rhs_i[31];
      neg_r_q <= lhs_i[31];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

>>> src/pee_datapath.sv
module pee_datapath #(
  parameter int StackDepth = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        symbol_i,
  input  logic              last_symbol_i,
  input  pee_pkg::ctl_t     ctl_i,
  output pee_pkg::sts_t     sts_o,
  output logic [31:0]       value_o,
  output logic [2:0]        status_o
);
  import pee_pkg::*;

  localparam int AW = $clog2(StackDepth);
  localparam int DW = $clog2(StackDepth + 1);

  logic [31:0] mem [StackDepth];
  logic [31:0] rdata_q;
  logic [DW-1:0] depth_q;
  logic [2:0]  err_q;
  logic [7:0]  sym_q;
  logic        last_q;
  logic [31:0] lhs_q, rhs_q;
  logic [31:0] value_q;
  logic [2:0]  status_q;
  logic        alu_done;
  logic [31:0] alu_res;
  op_e         op;
  logic [AW-1:0] waddr, raddr;
  logic        we;
  logic [31:0] wdata;

  always_comb begin
    unique case (sym_q)
      SymPow:  op = OpPow;
      SymDiv:  op = OpDiv;
      SymMul:  op = OpMul;
      SymMod:  op = OpMod;
      SymAdd:  op = OpAdd;
      default: op = OpSub;
    endcase
  end

  pee_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.start_alu),
    .op_i    (op),
    .lhs_i   (lhs_q),
    .rhs_i   (rhs_q),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  // depth minus one / two; rd_next only with depth >= 2, the final rd_top at any depth
  always_comb begin
    raddr = '0;
    if (ctl_i.rd_top) raddr = AW'(depth_q - DW'(1));
    else if (ctl_i.rd_next) raddr = AW'(depth_q - DW'(2));
    waddr = AW'(depth_q);
    we    = ctl_i.push_digit | ctl_i.push_res;
    wdata = ctl_i.push_digit ? {28'd0, sym_q[3:0] - SymZero[3:0]} : alu_res;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    if (ctl_i.load_sym) begin
      sym_q  <= symbol_i;
      last_q <= last_symbol_i;
    end
    if (ctl_i.cap_rhs) rhs_q <= rdata_q;
    if (ctl_i.cap_lhs) lhs_q <= rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      err_q    <= ErrNone;
      value_q  <= '0;
      status_q <= ErrNone;
    end else begin
      if (ctl_i.finish) begin
        depth_q <= '0;
        err_q   <= ErrNone;
      end else begin
        if (ctl_i.set_err) err_q <= ctl_i.err;
        if (we) depth_q <= depth_q + DW'(1);
        else if (ctl_i.pop2) depth_q <= depth_q - DW'(2);
      end
      if (ctl_i.cap_out) begin
        if (err_q != ErrNone) begin
          status_q <= err_q; value_q <= '0;
        end else if (depth_q != DW'(1)) begin
          status_q <= ErrLeftover; value_q <= '0;
        end else begin
          status_q <= ErrNone; value_q <= rdata_q;
        end
      end
    end
  end

  assign sts_o.is_space = (sym_q == SymSpace);
  assign sts_o.is_digit = (sym_q >= SymZero) && (sym_q <= SymNine);
  assign sts_o.is_op    = (sym_q == SymPow) || (sym_q == SymDiv) || (sym_q == SymMul) ||
                          (sym_q == SymMod) || (sym_q == SymAdd) || (sym_q == SymSub);
  assign sts_o.is_div   = (sym_q == SymDiv) || (sym_q == SymMod);
  assign sts_o.rhs_zero = (rhs_q == 32'd0);
  assign sts_o.full     = (depth_q >= DW'(StackDepth));
  assign sts_o.lt_two   = (depth_q < DW'(2));
  assign sts_o.err_set  = (err_q != ErrNone);
  assign sts_o.last     = last_q;
  assign sts_o.alu_done = alu_done;
  assign value_o  = value_q;
  assign status_o = status_q;
endmodule

>>> src/pee_ctrl.sv
module pee_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  pee_pkg::sts_t  sts_i,
  output pee_pkg::ctl_t  ctl_o
);
  import pee_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDec   = 4'd1;
  localparam logic [3:0] StRdTop = 4'd2;
  localparam logic [3:0] StRdNxt = 4'd3;
  localparam logic [3:0] StCapL  = 4'd4;
  localparam logic [3:0] StAlu   = 4'd5;
  localparam logic [3:0] StWait  = 4'd6;
  localparam logic [3:0] StEnd   = 4'd7;
  localparam logic [3:0] StEndRd = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q & out_stall_i;
    ctl_o    = '0;
    ctl_o.err = ErrNone;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        ctl_o.load_sym = 1'b1;
        state_d = StDec;
      end
      StDec: begin
        state_d = StEnd;
        if (sts_i.err_set || sts_i.is_space) begin
          state_d = StEnd;
        end else if (sts_i.is_digit) begin
          if (sts_i.full) begin
            ctl_o.set_err = 1'b1; ctl_o.err = ErrOverflow;
          end else ctl_o.push_digit = 1'b1;
        end else if (sts_i.is_op) begin
          if (sts_i.lt_two) begin
            ctl_o.set_err = 1'b1; ctl_o.err = ErrUnderflow;
          end else begin
            ctl_o.rd_top = 1'b1;
            state_d = StRdTop;
          end
        end else begin
          ctl_o.set_err = 1'b1; ctl_o.err = ErrBadSym;
        end
      end
      StRdTop: begin
        ctl_o.cap_rhs = 1'b1;
        ctl_o.rd_next = 1'b1;
        state_d = StRdNxt;
      end
      StRdNxt: begin
        ctl_o.cap_lhs = 1'b1;
        ctl_o.pop2 = 1'b1;
        state_d = StCapL;
      end
      StCapL: begin
        if (sts_i.is_div && sts_i.rhs_zero) begin
          ctl_o.set_err = 1'b1; ctl_o.err = ErrDivZero;
          state_d = StEnd;
        end else begin
          ctl_o.start_alu = 1'b1;
          state_d = StWait;
        end
      end
      StWait: if (sts_i.alu_done) begin
        ctl_o.push_res = 1'b1;
        state_d = StEnd;
      end
      StEnd: begin
        if (!sts_i.last) state_d = StIdle;
        else begin
          ctl_o.rd_top = 1'b1;  // bottom entry when depth is one
          state_d = StEndRd;
        end
      end
      StEndRd: if (!ovalid_q) begin
        ctl_o.cap_out = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        ctl_o.finish = 1'b1;
        ovalid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ovalid_q;
endmodule

>>> src/postfix_expression_evaluator.sv
// Postfix evaluator: one ASCII character per request, last_symbol_i marks the
// end of an expression, and that request yields one result (value, status).
// A request is taken only while idle; / and % use a divider that retires one
// quotient bit per cycle, ^ retires one exponent bit per cycle, so both take
// longer than + - *. The last request also reads out the result; a result
// waiting on out_stall_i holds the controller only at the end of the next expression.
module postfix_expression_evaluator #(
  parameter int StackDepth = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         symbol_i,
  input  logic               last_symbol_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o
);
  import pee_pkg::*;
  `include "postfix_expression_evaluator_assert.svh"

  ctl_t        ctl;
  sts_t        sts;
  logic [31:0] value_raw;

  pee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pee_datapath #(.StackDepth(StackDepth)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .value_o       (value_raw),
    .status_o      (status_o)
  );

  assign value_o = $signed(value_raw);

  `PEE_ASSERT(a_status_range, status_o <= ErrLeftover, "status out of range")
  `PEE_ASSERT(a_err_value_zero, !out_valid_o || status_o == ErrNone || value_raw == 32'd0,
    "nonzero value with error")
  `PEE_ASSERT_NEXT(a_no_push_overflow, ctl.push_digit, !ctl.push_digit,
    "back to back digit push")
endmodule
